// ===== hdl/soc_pkg.sv =====
// Shared widths, register map, reset values and mode codes of the sonar obstacle classifier.
`default_nettype none

package soc_pkg;

   // Field widths
   localparam int RANGE_W = 16;
   localparam int TIMER_W = 24;
   localparam int MODE_W  = 3;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 3;

   // Register indexes, byte address is 4 times the index
   localparam logic [INDEX_W-1:0] REG_COLLISION = 3'd0;
   localparam logic [INDEX_W-1:0] REG_JUMP      = 3'd1;
   localparam logic [INDEX_W-1:0] REG_NEAR_LOW  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_NEAR_HIGH = 3'd3;
   localparam logic [INDEX_W-1:0] REG_BLOCK     = 3'd4;
   localparam logic [INDEX_W-1:0] REG_DELAY     = 3'd5;

   // Register reset values
   localparam logic [RANGE_W-1:0] COLLISION_RST = 16'd600;
   localparam logic [RANGE_W-1:0] JUMP_RST      = 16'd2000;
   localparam logic [RANGE_W-1:0] NEAR_LOW_RST  = 16'd250;
   localparam logic [RANGE_W-1:0] NEAR_HIGH_RST = 16'd450;
   localparam logic [RANGE_W-1:0] BLOCK_RST     = 16'd120;
   localparam logic [TIMER_W-1:0] DELAY_RST     = 24'd250;

   // Word kinds on the request channel
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Result modes
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NEAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/soc_req_if.sv =====
// Request channel: sonar sample or tick word with valid/ready handshake.
`default_nettype none

interface soc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [soc_pkg::RANGE_W-1:0] left_mm;
   logic [soc_pkg::RANGE_W-1:0] center_mm;
   logic [soc_pkg::RANGE_W-1:0] right_mm;

   modport source (output valid, output req_type, output left_mm, output center_mm,
                   output right_mm, input ready);
   modport sink   (input valid, input req_type, input left_mm, input center_mm,
                   input right_mm, output ready);
endinterface

`default_nettype wire

// ===== hdl/soc_rsp_if.sv =====
// Result channel: obstacle mode word with valid/ready handshake.
`default_nettype none

interface soc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [soc_pkg::MODE_W-1:0] mode;

   modport source (output valid, output mode, input ready);
   modport sink   (input valid, input mode, output ready);
endinterface

`default_nettype wire

// ===== hdl/sonar_obstacle_classifier.sv =====
// Top level of the sonar obstacle classifier: input register, classify logic, result register.
//
//   channel  | direction | handshake            | payload
//   req      | in        | valid / ready        | req_type, left_mm, center_mm, right_mm
//   rsp      | out       | valid / ready        | mode
//   csr      | in        | APB psel/penable     | 32-bit registers at 4*index
//
// One word per cycle unless a sample waits on a stalled rsp: a word is held in the input
// register, is classified there against the stored ranges and timer, and a sample's mode
// lands in the result register, which drives rsp valid. Ticks update the timer only.
// Synchronous active-high reset restores registers, clears the timer and pipeline.
// A stalled rsp holds its word; the input register then holds samples, ticks still pass.
`default_nettype none

module sonar_obstacle_classifier (
   input  wire logic                          clock,
   input  wire logic                          reset,
   soc_req_if.sink                            req,
   soc_rsp_if.source                          rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [soc_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [soc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic      [soc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   // Configuration registers
   logic [soc_pkg::RANGE_W-1:0] collision_ff, jump_ff, near_low_ff, near_high_ff, block_ff;
   logic [soc_pkg::TIMER_W-1:0] delay_ff;
   logic [soc_pkg::INDEX_W-1:0] csr_index;
   logic                        csr_write;

   // Input register
   logic                        s1_valid_ff;
   logic                        s1_type_ff;
   logic [soc_pkg::RANGE_W-1:0] s1_left_ff, s1_center_ff, s1_right_ff;
   logic                        s1_fire;
   logic                        out_free;

   // Classifier state
   logic                        first_ff, first_in;
   logic [soc_pkg::RANGE_W-1:0] prev_left_ff, prev_center_ff, prev_right_ff;
   logic [soc_pkg::RANGE_W-1:0] prev_left_in, prev_center_in, prev_right_in;
   logic                        expired_ff, expired_in;
   logic                        running_ff, running_in;
   logic [soc_pkg::TIMER_W-1:0] count_ff, count_in;

   // Result register
   logic                        rsp_valid_ff;
   logic [soc_pkg::MODE_W-1:0]  rsp_mode_ff, mode_in;

   // Classify datapath
   logic [soc_pkg::RANGE_W-1:0] before_left, before_center, before_right, tested;
   logic                        all_clear, drop_left, drop_center, drop_right, any_drop;
   logic                        right_side, in_window;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[soc_pkg::ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         collision_ff <= soc_pkg::COLLISION_RST;
         jump_ff      <= soc_pkg::JUMP_RST;
         near_low_ff  <= soc_pkg::NEAR_LOW_RST;
         near_high_ff <= soc_pkg::NEAR_HIGH_RST;
         block_ff     <= soc_pkg::BLOCK_RST;
         delay_ff     <= soc_pkg::DELAY_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            soc_pkg::REG_COLLISION: collision_ff <= csr_pwdata[soc_pkg::RANGE_W-1:0];
            soc_pkg::REG_JUMP:      jump_ff      <= csr_pwdata[soc_pkg::RANGE_W-1:0];
            soc_pkg::REG_NEAR_LOW:  near_low_ff  <= csr_pwdata[soc_pkg::RANGE_W-1:0];
            soc_pkg::REG_NEAR_HIGH: near_high_ff <= csr_pwdata[soc_pkg::RANGE_W-1:0];
            soc_pkg::REG_BLOCK:     block_ff     <= csr_pwdata[soc_pkg::RANGE_W-1:0];
            soc_pkg::REG_DELAY:     delay_ff     <= csr_pwdata[soc_pkg::TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // Read configuration
   always_comb begin
      unique case (csr_index)
         soc_pkg::REG_COLLISION: csr_prdata = {16'd0, collision_ff};
         soc_pkg::REG_JUMP:      csr_prdata = {16'd0, jump_ff};
         soc_pkg::REG_NEAR_LOW:  csr_prdata = {16'd0, near_low_ff};
         soc_pkg::REG_NEAR_HIGH: csr_prdata = {16'd0, near_high_ff};
         soc_pkg::REG_BLOCK:     csr_prdata = {16'd0, block_ff};
         soc_pkg::REG_DELAY:     csr_prdata = {8'd0, delay_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // Handshake: samples need room in the result register, ticks never do
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_fire   = s1_valid_ff && ((s1_type_ff == soc_pkg::KIND_TICK) || out_free);
   assign req.ready = !s1_valid_ff || s1_fire;

   // Load the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_type_ff   <= req.req_type;
         s1_left_ff   <= req.left_mm;
         s1_center_ff <= req.center_mm;
         s1_right_ff  <= req.right_mm;
      end
   end

   // Compare against stored ranges; the first sample compares with itself
   always_comb begin
      before_left   = first_ff ? s1_left_ff   : prev_left_ff;
      before_center = first_ff ? s1_center_ff : prev_center_ff;
      before_right  = first_ff ? s1_right_ff  : prev_right_ff;
      all_clear     = (s1_left_ff > collision_ff) && (s1_center_ff > collision_ff) &&
                      (s1_right_ff > collision_ff);
      drop_left     = (before_left > s1_left_ff) &&
                      ((before_left - s1_left_ff) > jump_ff);
      drop_center   = (before_center > s1_center_ff) &&
                      ((before_center - s1_center_ff) > jump_ff);
      drop_right    = (before_right > s1_right_ff) &&
                      ((before_right - s1_right_ff) > jump_ff);
      any_drop      = drop_left || drop_center || drop_right;
      right_side    = (s1_left_ff > collision_ff) && (s1_right_ff < collision_ff);
      tested        = right_side ? s1_right_ff : s1_left_ff;
      in_window     = (tested > near_low_ff) && (tested < near_high_ff);
   end

   // Next state and mode
   always_comb begin
      first_in       = first_ff;
      prev_left_in   = prev_left_ff;
      prev_center_in = prev_center_ff;
      prev_right_in  = prev_right_ff;
      expired_in     = expired_ff;
      running_in     = running_ff;
      count_in       = count_ff;
      mode_in        = soc_pkg::MODE_CLEAR;
      if (s1_type_ff == soc_pkg::KIND_TICK) begin
         // count down a running timer
         if (running_ff) begin
            if (count_ff <= 24'd1) begin
               expired_in = 1'b1;
               running_in = 1'b0;
               count_in   = '0;
            end else begin
               count_in = count_ff - 24'd1;
            end
         end
      end else begin
         first_in = 1'b0;
         if (first_ff || !all_clear) begin
            prev_left_in   = s1_left_ff;
            prev_center_in = s1_center_ff;
            prev_right_in  = s1_right_ff;
         end
         if (all_clear) begin
            running_in = 1'b0;
            expired_in = 1'b0;
         end else if (!any_drop) begin
            if (in_window) begin
               mode_in    = soc_pkg::MODE_NEAR;
               expired_in = 1'b1;
               running_in = 1'b0;
            end else if (expired_ff) begin
               mode_in = right_side ? soc_pkg::MODE_RIGHT : soc_pkg::MODE_LEFT;
            end else if (!running_ff) begin
               running_in = 1'b1;
               count_in   = delay_ff;
            end
            if (s1_center_ff < block_ff) begin
               mode_in = soc_pkg::MODE_BLOCK;
            end
         end
      end
   end

   // Advance classifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff       <= 1'b1;
         prev_left_ff   <= '0;
         prev_center_ff <= '0;
         prev_right_ff  <= '0;
         expired_ff     <= 1'b0;
         running_ff     <= 1'b0;
         count_ff       <= '0;
      end else if (s1_fire) begin
         first_ff       <= first_in;
         prev_left_ff   <= prev_left_in;
         prev_center_ff <= prev_center_in;
         prev_right_ff  <= prev_right_in;
         expired_ff     <= expired_in;
         running_ff     <= running_in;
         count_ff       <= count_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && (s1_type_ff == soc_pkg::KIND_SAMPLE)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && (s1_type_ff == soc_pkg::KIND_SAMPLE)) begin
         rsp_mode_ff <= mode_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.mode  = rsp_mode_ff;

endmodule

`default_nettype wire

// ===== hdl/soc_checker.sv =====
// Port-level checks of the sonar obstacle classifier and their bind.
`default_nettype none

module soc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [soc_pkg::MODE_W-1:0]  rsp_mode,
   input wire logic                        csr_psel,
   input wire logic                        csr_penable,
   input wire logic                        csr_pwrite,
   input wire logic [soc_pkg::ADDR_W-1:0]  csr_paddr,
   input wire logic [soc_pkg::DATA_W-1:0]  csr_pwdata,
   input wire logic [soc_pkg::DATA_W-1:0]  csr_prdata,
   input wire logic                        csr_pready
);

   // No result word right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Only defined modes leave the block
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode <= soc_pkg::MODE_BLOCK))
      else $error("undefined mode on result");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mode)))
      else $error("stalled result changed");

   // A written collision range reads back while the address stays
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       (csr_paddr[soc_pkg::ADDR_W-1:2] == soc_pkg::REG_COLLISION))
      |=> ((csr_paddr != $past(csr_paddr)) ||
           (csr_prdata[soc_pkg::RANGE_W-1:0] == $past(csr_pwdata[soc_pkg::RANGE_W-1:0]))))
      else $error("collision range readback mismatch");

endmodule

bind sonar_obstacle_classifier soc_checker u_soc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_mode    (rsp.mode),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

`default_nettype wire

// ===== tb/soc_mode_checker.sv =====
// Checker for the sonar obstacle classifier: tracks config writes, predicts modes, compares.
`timescale 1ns / 1ps

module soc_mode_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_type,
   input  logic [soc_pkg::RANGE_W-1:0] req_left_mm,
   input  logic [soc_pkg::RANGE_W-1:0] req_center_mm,
   input  logic [soc_pkg::RANGE_W-1:0] req_right_mm,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [soc_pkg::MODE_W-1:0]  rsp_mode,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic                        csr_pready,
   input  logic [soc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [soc_pkg::DATA_W-1:0]  csr_pwdata,
   output int                          mismatches,
   output int                          waiting
);
   import soc_pkg::*;

   // Shadow registers
   logic [RANGE_W-1:0] collision_thr;
   logic [RANGE_W-1:0] jump_thr;
   logic [RANGE_W-1:0] near_lo;
   logic [RANGE_W-1:0] near_hi;
   logic [RANGE_W-1:0] block_thr;
   logic [TIMER_W-1:0] delay_len;

   // Shadow state of the classifier
   logic               no_sample_yet;
   logic [RANGE_W-1:0] last_left;
   logic [RANGE_W-1:0] last_center;
   logic [RANGE_W-1:0] last_right;
   logic               confirm_done;
   logic               confirm_running;
   logic [TIMER_W-1:0] confirm_count;

   logic [MODE_W-1:0]  pending_modes[$];

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic logic fell_too_far(input logic [RANGE_W-1:0] was,
                                         input logic [RANGE_W-1:0] now);
      return (was > now) && ((was - now) > jump_thr);
   endfunction

   task automatic restore_defaults();
      collision_thr   = COLLISION_RST;
      jump_thr        = JUMP_RST;
      near_lo         = NEAR_LOW_RST;
      near_hi         = NEAR_HIGH_RST;
      block_thr       = BLOCK_RST;
      delay_len       = DELAY_RST;
      no_sample_yet   = 1'b1;
      last_left       = '0;
      last_center     = '0;
      last_right      = '0;
      confirm_done    = 1'b0;
      confirm_running = 1'b0;
      confirm_count   = '0;
      pending_modes.delete();
   endtask

   task automatic write_shadow(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      case (idx)
         REG_COLLISION: collision_thr = value[RANGE_W-1:0];
         REG_JUMP:      jump_thr      = value[RANGE_W-1:0];
         REG_NEAR_LOW:  near_lo       = value[RANGE_W-1:0];
         REG_NEAR_HIGH: near_hi       = value[RANGE_W-1:0];
         REG_BLOCK:     block_thr     = value[RANGE_W-1:0];
         REG_DELAY:     delay_len     = value[TIMER_W-1:0];
         default: ;
      endcase
   endtask

   // Advance the timer on a tick, or classify a sample and queue its mode
   task automatic classify_word(input logic kind, input logic [RANGE_W-1:0] l,
                                input logic [RANGE_W-1:0] c, input logic [RANGE_W-1:0] r);
      logic [RANGE_W-1:0] was_l, was_c, was_r, probe;
      logic               right_side;
      logic [MODE_W-1:0]  m;
      if (kind == KIND_TICK) begin
         if (confirm_running) begin
            if (confirm_count <= 1) begin
               confirm_done    = 1'b1;
               confirm_running = 1'b0;
               confirm_count   = '0;
            end else begin
               confirm_count = confirm_count - 1'b1;
            end
         end
      end else begin
         m = MODE_CLEAR;
         if (no_sample_yet) begin
            last_left     = l;
            last_center   = c;
            last_right    = r;
            no_sample_yet = 1'b0;
         end
         if (l > collision_thr && c > collision_thr && r > collision_thr) begin
            // all clear: cancel the timer, keep the stored ranges
            confirm_running = 1'b0;
            confirm_done    = 1'b0;
         end else begin
            was_l = last_left;
            was_c = last_center;
            was_r = last_right;
            last_left   = l;
            last_center = c;
            last_right  = r;
            if (!(fell_too_far(was_l, l) || fell_too_far(was_r, r) ||
                  fell_too_far(was_c, c))) begin
               right_side = (l > collision_thr) && (r < collision_thr);
               probe = right_side ? r : l;
               if (probe > near_lo && probe < near_hi) begin
                  m = MODE_NEAR;
                  confirm_done    = 1'b1;
                  confirm_running = 1'b0;
               end else if (confirm_done) begin
                  m = right_side ? MODE_RIGHT : MODE_LEFT;
               end else begin
                  if (!confirm_running) begin
                     confirm_running = 1'b1;
                     confirm_count   = delay_len;
                  end
               end
               if (c < block_thr) m = MODE_BLOCK;
            end
         end
         pending_modes.push_back(m);
      end
   endtask

   // Watch config, result and request channels at each edge
   always @(posedge clock) begin
      logic [MODE_W-1:0] want;
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_shadow(csr_paddr[ADDR_W-1:2], csr_pwdata);
         if (rsp_valid && rsp_ready) begin
            if (pending_modes.size() == 0) begin
               report_mismatch($sformatf("result mode %0d with nothing expected", rsp_mode));
            end else begin
               want = pending_modes.pop_front();
               if (rsp_mode !== want)
                  report_mismatch($sformatf("mode expected %0d, got %0d", want, rsp_mode));
            end
         end
         if (req_valid && req_ready)
            classify_word(req_type, req_left_mm, req_center_mm, req_right_mm);
      end
      waiting <= pending_modes.size();
   end

endmodule

// ===== tb/sonar_obstacle_classifier_tb.sv =====
// Testbench top for the sonar obstacle classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sonar_obstacle_classifier_tb;
   import soc_pkg::*;

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;
   int                  mismatch_total;
   int                  mode_backlog;

   // Current settings, used only to aim the random ranges and size the tick bursts
   int                  cfg_coll, cfg_jump, cfg_nl, cfg_nh, cfg_blk, cfg_delay;
   bit                  steady;
   int                  ready_hold;

   soc_req_if req_if();
   soc_rsp_if rsp_if();

   sonar_obstacle_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   soc_mode_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_type      (req_if.req_type),
      .req_left_mm   (req_if.left_mm),
      .req_center_mm (req_if.center_mm),
      .req_right_mm  (req_if.right_mm),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_mode      (rsp_if.mode),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .mismatches    (mismatch_total),
      .waiting       (mode_backlog)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Stall lengths: mostly short, a few long
   function automatic int stall_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int req_gap();
      if (steady || $urandom_range(0, 99) < 55) return 0;
      return stall_len();
   endfunction

   function automatic logic [RANGE_W-1:0] clamp16(input int v);
      if (v < 0) return '0;
      if (v > 65535) return 16'hFFFF;
      return v[RANGE_W-1:0];
   endfunction

   // Aim a range at the thresholds now in force
   function automatic logic [RANGE_W-1:0] pick_range();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 65535;
         2: v = cfg_coll + int'($urandom_range(0, 4)) - 2;
         3: v = (cfg_nh > cfg_nl + 1) ? int'($urandom_range(cfg_nl + 1, cfg_nh - 1)) : cfg_nl;
         4: v = (cfg_blk > 0) ? int'($urandom_range(0, cfg_blk - 1)) : 0;
         5, 6: v = cfg_coll + 1 + int'($urandom_range(0, 3000));
         7: v = ($urandom_range(0, 1) ? cfg_nl : cfg_nh) + int'($urandom_range(0, 2)) - 1;
         8: v = $urandom_range(0, 65535);
         default: v = $urandom_range(0, cfg_coll);
      endcase
      return clamp16(v);
   endfunction

   // Result side: random stalls, or always ready in steady stretches
   always @(negedge clock) begin
      if (steady) begin
         rsp_if.ready <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold = stall_len();
      end else begin
         rsp_if.ready <= 1'b1;
         ready_hold = $urandom_range(0, 15);
      end
   end

   // Offer one word after a random gap and hold it until taken
   task automatic push_word(input logic kind, input int l, input int c, input int r);
      int gap;
      gap = req_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.left_mm   <= clamp16(l);
      req_if.center_mm <= clamp16(c);
      req_if.right_mm  <= clamp16(r);
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic sample(input int l, input int c, input int r);
      push_word(KIND_SAMPLE, l, c, r);
   endtask

   task automatic tick();
      push_word(KIND_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));
   endtask

   // Drop valid and let every expected mode drain, plus the pipeline depth
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (mode_backlog != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write all six registers; upper data bits carry junk
   task automatic set_config(input int coll, input int jump, input int nl, input int nh,
                             input int blk, input int dly);
      logic [DATA_W-1:0] junk;
      junk = $urandom;
      write_reg(REG_COLLISION, {junk[31:16], coll[15:0]});
      junk = $urandom;
      write_reg(REG_JUMP, {junk[31:16], jump[15:0]});
      junk = $urandom;
      write_reg(REG_NEAR_LOW, {junk[31:16], nl[15:0]});
      junk = $urandom;
      write_reg(REG_NEAR_HIGH, {junk[31:16], nh[15:0]});
      junk = $urandom;
      write_reg(REG_BLOCK, {junk[31:16], blk[15:0]});
      junk = $urandom;
      write_reg(REG_DELAY, {junk[31:24], dly[23:0]});
      cfg_coll  = coll;
      cfg_jump  = jump;
      cfg_nl    = nl;
      cfg_nh    = nh;
      cfg_blk   = blk;
      cfg_delay = dly;
   endtask

   // Random words: mostly samples aimed at the thresholds, ticks in bursts
   task automatic random_words(input int count);
      int sent, burst, k, clr;
      sent = 0;
      while (sent < count) begin
         if (sent % 50 == 0) steady = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 99) < 30) begin
            burst = $urandom_range(1, (cfg_delay + 1 < 30) ? cfg_delay + 1 : 30);
            for (k = 0; k < burst; k++) tick();
            sent += burst;
         end else if ($urandom_range(0, 99) < 15) begin
            clr = cfg_coll + 1;
            sample(clr + int'($urandom_range(0, 5000)), clr + int'($urandom_range(0, 5000)),
                   clr + int'($urandom_range(0, 5000)));
            sent++;
         end else begin
            sample(pick_range(), pick_range(), pick_range());
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      int p;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = KIND_SAMPLE;
      req_if.left_mm   = '0;
      req_if.center_mm = '0;
      req_if.right_mm  = '0;
      rsp_if.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      steady           = 1'b0;
      ready_hold       = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: defaults with a short timer
      set_config(600, 2000, 250, 450, 120, 3);
      sample(0, 0, 0);               // first sample, center block
      sample(65535, 65535, 65535);   // all clear
      sample(500, 5000, 5000);       // left obstacle, timer starts
      tick();
      sample(500, 5000, 5000);       // timer already running, no reload
      tick();
      tick();                        // timer expires
      tick();                        // tick while stopped
      sample(500, 5000, 5000);       // left or front
      sample(5000, 5000, 500);       // right drop beyond jump limit
      sample(5000, 5000, 500);       // right obstacle
      sample(5000, 5000, 600);       // right at collision, not below it
      sample(600, 5000, 5000);       // left at collision counts as obstacle
      sample(300, 5000, 5000);       // too close
      sample(250, 5000, 5000);       // window bounds are exclusive
      sample(450, 5000, 5000);
      sample(449, 119, 5000);        // center drop beyond jump limit
      sample(449, 119, 5000);        // center block overrides too close
      sample(449, 120, 5000);
      sample(2600, 2600, 2600);      // clear, stored ranges kept
      sample(400, 3000, 3000);       // drop equal to jump limit is fine
      sample(400, 3000, 999);        // drop one past the limit
      sample(65535, 0, 65535);
      sample(65535, 0, 65535);
      drain();

      // Random phases over several settings: defaults, then extremes, then other settings
      set_config(600, 2000, 250, 450, 120, 5);
      random_words(110);
      drain();
      set_config(0, 0, 0, 0, 0, 1);
      random_words(80);
      drain();
      set_config(65535, 65535, 65535, 65535, 65535, 16777215);
      random_words(60);
      drain();
      set_config(65535, 0, 0, 65535, 65535, 0);
      random_words(80);
      drain();
      set_config(1000, 500, 100, 900, 300, 2);
      random_words(100);
      drain();
      for (p = 0; p < 4; p++) begin
         cfg_nl = $urandom_range(0, 600);
         set_config($urandom_range(100, 3000), $urandom_range(0, 5000), cfg_nl,
                    cfg_nl + int'($urandom_range(0, 800)), $urandom_range(0, 400),
                    $urandom_range(1, 12));
         random_words(90);
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_total == 0 && mode_backlog == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
